>>> src/first_fit_free_list_allocator_core_assert.svh
// assertion macros for the first-fit allocator core
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffa assertion failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffa assertion failed");

`endif

>>> src/ffa_pkg.sv
// types and constants shared by the first-fit allocator core
// no dependencies
package ffa_pkg;

    localparam logic [31:0] BLOCK_MAGIC = 32'd1234567;
    localparam int          HDR_BYTES   = 8;
    localparam int          FIRST_HDR   = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE,
        S_A_SZ, S_A_LNK, S_A_NXT, S_A_SPL1, S_A_SPL2, S_A_PLNK, S_A_MAGIC,
        S_F_CHK, S_F_SZ, S_F_LNK, S_F_INS, S_F_PLNK,
        S_M0, S_M1, S_M2, S_M3, S_M4,
        S_RESP
    } t_state;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

endpackage

>>> src/ffa_if.sv
// request and response channel interfaces of the allocator core
// depends on nothing
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] request_bytes;
    logic [11:0] block_address;
    modport source (output valid, action, request_bytes, block_address, input ready);
    modport sink   (input valid, action, request_bytes, block_address, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] payload_address;
    logic [7:0]  blocks_in_use;
    modport source (output valid, status, payload_address, blocks_in_use, input ready);
    modport sink   (input valid, status, payload_address, blocks_in_use, output ready);
endinterface

>>> src/ffa_arena.sv
// single-port arena memory, registered read
// depends on ffa_pkg
module ffa_arena #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
) (
    input  logic               i_clk,
    input  ffa_pkg::t_mem_ctl  i_ctl,
    input  logic [IW-1:0]      i_idx,
    input  logic [31:0]        i_wdata,
    output logic [31:0]        o_rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                mem[i_idx] <= i_wdata;
            end else begin
                r_rdata <= mem[i_idx];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/first_fit_free_list_allocator_core.sv
// First-fit allocator core over a byte arena with an address-ordered free list.
// Request channel i_req: action (0 alloc, 1 free), request_bytes, block_address.
// Response channel o_rsp: status, payload_address, blocks_in_use; one per request.
// Block headers (size word, link/magic word) live in a single-port arena RAM
// of HEAP_BYTES/4 words with a registered read; every step of a list walk is
// one RAM access, so the RAM port sets the pace.
// Rejected requests go straight to the response. An alloc reads each free block's
// size and link until one fits, splits it when the rest can hold a header and
// MIN_PAYLOAD bytes, then relinks the list and writes the magic word. A free
// checks the magic word, links the block in directly on an empty list, else walks
// the list to its place, links it in and merges it with each adjacent free neighbor.
// One request is worked on at a time; the next is taken once the result is
// in the output register, which holds it while o_rsp.ready is low. If the
// previous result is still held, a finished result waits until it drains.
// After reset the core writes the initial free header (ready low), then the
// whole arena is one free block at offset 4.
// depends on ffa_pkg, ffa_if, ffa_arena, first_fit_free_list_allocator_core_assert.svh
`include "first_fit_free_list_allocator_core_assert.svh"

module first_fit_free_list_allocator_core #(
    parameter int HEAP_BYTES  = 4096,
    parameter int MIN_PAYLOAD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffa_req_if.sink     i_req,
    ffa_rsp_if.source   o_rsp
);
    localparam int AW         = $clog2(HEAP_BYTES);
    localparam int DEPTH      = HEAP_BYTES / 4;
    localparam int IW         = $clog2(DEPTH);
    localparam int WALK_LIMIT = HEAP_BYTES / 8 + 1;
    localparam int CW         = $clog2(WALK_LIMIT + 1);

    ffa_pkg::t_state  r_state, n_state;
    logic [11:0]      r_req, n_req;
    logic [AW-1:0]    r_cur, n_cur, r_prev, n_prev, r_hdr, n_hdr;
    logic [AW-1:0]    r_repl, n_repl, r_nxt, n_nxt, r_ma, n_ma, r_mb, n_mb;
    logic [AW-1:0]    r_head, n_head;
    logic [31:0]      r_fs, n_fs, r_sb, n_sb;
    logic             r_second, n_second, r_nonempty, n_nonempty;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [7:0]       r_used, n_used;
    ffa_pkg::t_status r_status, n_status;
    logic [11:0]      r_paddr, n_paddr;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_ostatus, n_ostatus;
    logic [11:0]      r_oaddr, n_oaddr;
    logic [7:0]       r_oused, n_oused;

    ffa_pkg::t_mem_ctl m_ctl;
    logic [AW-1:0]     m_off;
    logic [31:0]       m_wdata, m_rdata;
    logic              accept;
    logic              last_step;

    ffa_arena #(.DEPTH(DEPTH), .IW(IW)) u_arena (
        .i_clk   (i_clk),
        .i_ctl   (m_ctl),
        .i_idx   (m_off[AW-1:2]),
        .i_wdata (m_wdata),
        .o_rdata (m_rdata)
    );

    assign i_req.ready           = (r_state == ffa_pkg::S_IDLE);
    assign accept                = i_req.valid && i_req.ready;
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_ostatus;
    assign o_rsp.payload_address = r_oaddr;
    assign o_rsp.blocks_in_use   = r_oused;
    assign last_step             = (r_cnt + CW'(1)) >= CW'(WALK_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ffa_pkg::S_INIT0;
            r_head     <= AW'(ffa_pkg::FIRST_HDR);
            r_nonempty <= 1'b1;
            r_used     <= '0;
            r_ovalid   <= 1'b0;
            r_second   <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_used     <= n_used;
            r_ovalid   <= n_ovalid;
            r_second   <= n_second;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_hdr     <= n_hdr;
        r_repl    <= n_repl;
        r_nxt     <= n_nxt;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_fs      <= n_fs;
        r_sb      <= n_sb;
        r_status  <= n_status;
        r_paddr   <= n_paddr;
        r_ostatus <= n_ostatus;
        r_oaddr   <= n_oaddr;
        r_oused   <= n_oused;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_hdr      = r_hdr;
        n_repl     = r_repl;
        n_nxt      = r_nxt;
        n_ma       = r_ma;
        n_mb       = r_mb;
        n_head     = r_head;
        n_fs       = r_fs;
        n_sb       = r_sb;
        n_second   = r_second;
        n_nonempty = r_nonempty;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_status   = r_status;
        n_paddr    = r_paddr;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_ostatus  = r_ostatus;
        n_oaddr    = r_oaddr;
        n_oused    = r_oused;
        m_ctl      = '0;
        m_off      = '0;
        m_wdata    = '0;

        unique case (r_state)
            ffa_pkg::S_INIT0: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = AW'(ffa_pkg::FIRST_HDR);
                m_wdata = 32'(HEAP_BYTES - ffa_pkg::FIRST_HDR - ffa_pkg::HDR_BYTES);
                n_state = ffa_pkg::S_INIT1;
            end
            ffa_pkg::S_INIT1: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = AW'(ffa_pkg::FIRST_HDR + 4);
                m_wdata = '0;
                n_state = ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_IDLE: begin
                if (accept) begin
                    n_req    = i_req.request_bytes;
                    n_paddr  = '0;
                    n_status = ffa_pkg::ST_OK;
                    n_cur    = r_head;
                    n_prev   = '0;
                    n_cnt    = '0;
                    if (!i_req.action) begin
                        if (i_req.request_bytes == '0 || i_req.request_bytes[2:0] != 3'd0) begin
                            n_status = ffa_pkg::ST_INVALID;
                            n_state  = ffa_pkg::S_RESP;
                        end else if (!r_nonempty) begin
                            n_status = ffa_pkg::ST_NO_SPACE;
                            n_state  = ffa_pkg::S_RESP;
                        end else begin
                            m_ctl   = '{en: 1'b1, we: 1'b0};
                            m_off   = r_head;
                            n_state = ffa_pkg::S_A_SZ;
                        end
                    end else begin
                        if (i_req.block_address == '0) begin
                            n_state = ffa_pkg::S_RESP;
                        end else if (i_req.block_address[2:0] != 3'd4
                                || i_req.block_address < 12'(ffa_pkg::FIRST_HDR
                                                             + ffa_pkg::HDR_BYTES)
                                || (32'(i_req.block_address) + 32'(MIN_PAYLOAD))
                                   > 32'(HEAP_BYTES)) begin
                            n_status = ffa_pkg::ST_INVALID;
                            n_state  = ffa_pkg::S_RESP;
                        end else begin
                            n_hdr   = AW'(i_req.block_address) - AW'(ffa_pkg::HDR_BYTES);
                            m_ctl   = '{en: 1'b1, we: 1'b0};
                            m_off   = AW'(i_req.block_address) - AW'(4);
                            n_state = ffa_pkg::S_F_CHK;
                        end
                    end
                end
            end
            ffa_pkg::S_A_SZ: begin
                n_fs    = m_rdata;
                m_ctl   = '{en: 1'b1, we: 1'b0};
                m_off   = r_cur + AW'(4);
                n_state = (m_rdata >= 32'(r_req)) ? ffa_pkg::S_A_NXT : ffa_pkg::S_A_LNK;
            end
            ffa_pkg::S_A_LNK: begin
                n_prev = r_cur;
                n_cur  = AW'(m_rdata);
                n_cnt  = r_cnt + CW'(1);
                if (m_rdata == '0 || last_step) begin
                    n_status = ffa_pkg::ST_NO_SPACE;
                    n_state  = ffa_pkg::S_RESP;
                end else begin
                    m_ctl   = '{en: 1'b1, we: 1'b0};
                    m_off   = AW'(m_rdata);
                    n_state = ffa_pkg::S_A_SZ;
                end
            end
            ffa_pkg::S_A_NXT: begin
                n_nxt = AW'(m_rdata);
                if ((r_fs - 32'(r_req)) < 32'(ffa_pkg::HDR_BYTES + MIN_PAYLOAD)) begin
                    n_repl  = AW'(m_rdata);
                    n_state = ffa_pkg::S_A_PLNK;
                end else begin
                    n_repl  = r_cur + AW'(ffa_pkg::HDR_BYTES) + AW'(r_req);
                    m_ctl   = '{en: 1'b1, we: 1'b1};
                    m_off   = n_repl;
                    m_wdata = r_fs - 32'(r_req) - 32'(ffa_pkg::HDR_BYTES);
                    n_state = ffa_pkg::S_A_SPL1;
                end
            end
            ffa_pkg::S_A_SPL1: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_repl + AW'(4);
                m_wdata = 32'(r_nxt);
                n_state = ffa_pkg::S_A_SPL2;
            end
            ffa_pkg::S_A_SPL2: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_cur;
                m_wdata = 32'(r_req);
                n_state = ffa_pkg::S_A_PLNK;
            end
            ffa_pkg::S_A_PLNK: begin
                if (r_prev != '0) begin
                    m_ctl   = '{en: 1'b1, we: 1'b1};
                    m_off   = r_prev + AW'(4);
                    m_wdata = 32'(r_repl);
                end else if (r_repl == '0) begin
                    n_nonempty = 1'b0;
                end else begin
                    n_head = r_repl;
                end
                n_state = ffa_pkg::S_A_MAGIC;
            end
            ffa_pkg::S_A_MAGIC: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_cur + AW'(4);
                m_wdata = ffa_pkg::BLOCK_MAGIC;
                if (r_used != 8'hFF) begin
                    n_used = r_used + 8'd1;
                end
                n_paddr = 12'(r_cur + AW'(ffa_pkg::HDR_BYTES));
                n_state = ffa_pkg::S_RESP;
            end
            ffa_pkg::S_F_CHK: begin
                if (m_rdata != ffa_pkg::BLOCK_MAGIC) begin
                    n_status = ffa_pkg::ST_NOT_ALLOC;
                    n_state  = ffa_pkg::S_RESP;
                end else begin
                    if (r_used != '0) begin
                        n_used = r_used - 8'd1;
                    end
                    if (!r_nonempty) begin
                        n_head     = r_hdr;
                        n_nonempty = 1'b1;
                        m_ctl      = '{en: 1'b1, we: 1'b1};
                        m_off      = r_hdr + AW'(4);
                        m_wdata    = '0;
                        n_state    = ffa_pkg::S_RESP;
                    end else begin
                        m_ctl   = '{en: 1'b1, we: 1'b0};
                        m_off   = r_cur;
                        n_state = ffa_pkg::S_F_SZ;
                    end
                end
            end
            ffa_pkg::S_F_SZ: begin
                if ((34'(r_cur) + 34'(m_rdata) + 34'(ffa_pkg::HDR_BYTES)) > 34'(r_hdr)) begin
                    n_state = ffa_pkg::S_F_INS;
                end else begin
                    m_ctl   = '{en: 1'b1, we: 1'b0};
                    m_off   = r_cur + AW'(4);
                    n_state = ffa_pkg::S_F_LNK;
                end
            end
            ffa_pkg::S_F_LNK: begin
                n_prev = r_cur;
                n_cur  = AW'(m_rdata);
                n_cnt  = r_cnt + CW'(1);
                if (m_rdata == '0 || last_step) begin
                    n_state = ffa_pkg::S_F_INS;
                end else begin
                    m_ctl   = '{en: 1'b1, we: 1'b0};
                    m_off   = AW'(m_rdata);
                    n_state = ffa_pkg::S_F_SZ;
                end
            end
            ffa_pkg::S_F_INS: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_hdr + AW'(4);
                m_wdata = 32'(r_cur);
                n_ma    = r_hdr;
                n_mb    = r_cur;
                if (r_prev != '0) begin
                    n_state = ffa_pkg::S_F_PLNK;
                end else begin
                    n_head   = r_hdr;
                    n_second = 1'b0;
                    n_state  = (r_cur != '0) ? ffa_pkg::S_M0 : ffa_pkg::S_RESP;
                end
            end
            ffa_pkg::S_F_PLNK: begin
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_prev + AW'(4);
                m_wdata = 32'(r_hdr);
                n_state = ffa_pkg::S_M0;
                if (r_cur != '0) begin
                    n_second = 1'b1;
                end else begin
                    n_second = 1'b0;
                    n_ma     = r_prev;
                    n_mb     = r_hdr;
                end
            end
            ffa_pkg::S_M0: begin
                m_ctl   = '{en: 1'b1, we: 1'b0};
                m_off   = r_ma;
                n_state = ffa_pkg::S_M1;
            end
            ffa_pkg::S_M1: begin
                n_fs = m_rdata;
                if ((34'(r_ma) + 34'(m_rdata) + 34'(ffa_pkg::HDR_BYTES)) != 34'(r_mb)) begin
                    n_second = 1'b0;
                    n_ma     = r_prev;
                    n_mb     = r_hdr;
                    n_state  = r_second ? ffa_pkg::S_M0 : ffa_pkg::S_RESP;
                end else begin
                    m_ctl   = '{en: 1'b1, we: 1'b0};
                    m_off   = r_mb;
                    n_state = ffa_pkg::S_M2;
                end
            end
            ffa_pkg::S_M2: begin
                n_sb    = m_rdata;
                m_ctl   = '{en: 1'b1, we: 1'b0};
                m_off   = r_mb + AW'(4);
                n_state = ffa_pkg::S_M3;
            end
            ffa_pkg::S_M3: begin
                n_nxt   = AW'(m_rdata);
                m_ctl   = '{en: 1'b1, we: 1'b1};
                m_off   = r_ma;
                m_wdata = r_fs + r_sb + 32'(ffa_pkg::HDR_BYTES);
                n_state = ffa_pkg::S_M4;
            end
            ffa_pkg::S_M4: begin
                m_ctl    = '{en: 1'b1, we: 1'b1};
                m_off    = r_ma + AW'(4);
                m_wdata  = 32'(r_nxt);
                n_second = 1'b0;
                n_ma     = r_prev;
                n_mb     = r_hdr;
                n_state  = r_second ? ffa_pkg::S_M0 : ffa_pkg::S_RESP;
            end
            ffa_pkg::S_RESP: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oaddr   = r_paddr;
                    n_oused   = r_used;
                    n_state   = ffa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `FFA_ASSERT_NXT(a_accept_leaves_idle, accept, r_state != ffa_pkg::S_IDLE)
    `FFA_ASSERT_IMP(a_fail_has_null_addr, o_rsp.valid && o_rsp.status != ffa_pkg::ST_OK,
                    o_rsp.payload_address == '0)
    `FFA_ASSERT_IMP(a_no_write_in_idle, m_ctl.we, r_state != ffa_pkg::S_IDLE)

endmodule
